// ===== hdl/hfve_pkg.sv =====
// Shared types and constants for the header field value extractor.
`timescale 1ns / 1ps
`default_nettype none

package hfve_pkg;

  // Width of the name length register and of the configuration data word.
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NAME_CHARS = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAME_FIRST  = 2'd0,
    CFG_NAME_SECOND = 2'd1,
    CFG_NAME_LENGTH = 2'd2
  } cfg_idx_e;

  // ASCII codes the scanner looks at.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Scan phase, one-hot.
  typedef enum logic [4:0] {
    PH_SEARCH   = 5'b00001,
    PH_COLON    = 5'b00010,
    PH_SKIP     = 5'b00100,
    PH_VALUE    = 5'b01000,
    PH_FINISHED = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
  } hfve_in_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_present;
    logic       lookup_done;
    logic       field_found;
  } hfve_out_t;

  // ASCII upper-case fold, letters only.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/header_field_value_extractor.sv =====
// Top level: streaming case-insensitive header field lookup and value extraction.
// Usage:
//   Header bytes enter on the in_* channel (valid/stall), one byte per request,
//   with end_of_block marking the last byte of a header block. Results leave on
//   the out_* channel (valid/stall): one request per value byte, then one final
//   request with lookup_done=1 whose field_found says whether a non-empty value
//   was extracted. A block always yields exactly one final request.
//   The field name is set through the write port (cfg_we_i/cfg_idx_i/
//   cfg_wdata_i) while the block is idle: name characters 0..7, 8..15, length.
// Timing:
//   One byte accepted per cycle while in_stall_o is low. The match compare over
//   the byte window is done in the cycle the byte is accepted; its results are
//   written to a 4-entry output queue, on out_* from the next cycle if it was empty.
//   A byte can produce two results (last value byte plus the final one), but
//   the name and colon bytes ahead of any value make none, so with the receiver
//   always ready the queue holds at most two and in_stall_o stays low.
// Reset: rst_ni clears the name registers, the scan state and the queue.
// Stall: with out_stall_i high the queue holds its head; in_stall_o rises
//   once fewer than two queue entries are free.
`timescale 1ns / 1ps
`default_nettype none

module header_field_value_extractor
  import hfve_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // byte input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire hfve_in_t             in_data_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output hfve_out_t                 out_data_o
);

  localparam int unsigned WIN_D  = MAX_NAME_LEN + 1;
  localparam int unsigned WIN_AW = $clog2(WIN_D);
  localparam int unsigned SEEN_W = $clog2(WIN_D + 1);
  localparam int unsigned Q_D    = 4;
  localparam int unsigned Q_AW   = 2;
  localparam int unsigned Q_CW   = 3;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] name_first_q, name_second_q;
  logic [LEN_W-1:0] name_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_first_q  <= '0;
      name_second_q <= '0;
      name_len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NAME_FIRST:  name_first_q  <= cfg_wdata_i;
        CFG_NAME_SECOND: name_second_q <= cfg_wdata_i;
        CFG_NAME_LENGTH: name_len_q    <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // name characters, character 0 first
  logic [7:0] name_c [NAME_CHARS];
  for (genvar k = 0; k < NAME_CHARS; k++) begin : g_name
    if (k < 8) begin : g_lo
      assign name_c[k] = name_first_q[8*k +: 8];
    end else begin : g_hi
      assign name_c[k] = name_second_q[8*(k-8) +: 8];
    end
  end

  // ---------------------------------------------------------------- scan state
  logic [7:0]        win_q [WIN_D];
  logic [7:0]        win_d [WIN_D];
  logic [SEEN_W-1:0] seen_q, seen_d;
  phase_e            phase_q, phase_d;
  logic              nonempty_q, nonempty_d;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // window after shifting in the current byte, newest at index 0
  logic [7:0]        win_new [WIN_D];
  logic [SEEN_W-1:0] seen_new;
  always_comb begin
    win_new[0] = in_data_i.data_byte;
    for (int i = 1; i < WIN_D; i++) begin
      win_new[i] = win_q[i-1];
    end
    seen_new = (seen_q == SEEN_W'(WIN_D)) ? seen_q : seen_q + SEEN_W'(1);
  end

  // parallel name compare: window position j holds name char len-1-j
  logic             len_ok;
  logic [LEN_W-1:0] seen_ext;
  logic [MAX_NAME_LEN-1:0] pos_ok;
  logic             name_hit;
  logic [WIN_AW-1:0] pre_idx;
  logic             at_line_start;

  assign len_ok   = (name_len_q != '0) && (name_len_q <= LEN_W'(MAX_NAME_LEN));
  assign seen_ext = LEN_W'(seen_new);

  for (genvar j = 0; j < MAX_NAME_LEN; j++) begin : g_cmp
    logic [3:0] c_idx;
    assign c_idx = 4'(name_len_q - LEN_W'(j) - LEN_W'(1));
    assign pos_ok[j] = (LEN_W'(j) >= name_len_q) ||
                       (fold_case(win_new[j]) == fold_case(name_c[c_idx]));
  end

  assign name_hit = len_ok && (seen_ext >= name_len_q) && (&pos_ok);
  assign pre_idx  = len_ok ? WIN_AW'(name_len_q) : '0;
  // name starts at block start or right after LF
  assign at_line_start = (seen_ext == name_len_q) || (win_new[pre_idx] == CH_LF);

  // ---------------------------------------------------------------- step logic
  hfve_out_t  res [2];
  logic [1:0] res_n;

  always_comb begin
    logic [7:0] b;
    b          = in_data_i.data_byte;
    phase_d    = phase_q;
    nonempty_d = nonempty_q;
    seen_d     = seen_new;
    res[0]     = '0;
    res[1]     = '0;
    res_n      = 2'd0;
    for (int i = 0; i < WIN_D; i++) begin
      win_d[i] = win_new[i];
    end

    case (phase_q)
      PH_SEARCH: begin
        if (name_hit) begin
          if (at_line_start) begin
            phase_d = PH_COLON;
          end else begin
            res[0]  = '{value_byte: 8'h00, byte_present: 1'b0,
                        lookup_done: 1'b1, field_found: 1'b0};
            res_n   = 2'd1;
            phase_d = PH_FINISHED;
          end
        end
      end
      PH_COLON: begin
        if (b == CH_COLON) begin
          phase_d = PH_SKIP;
        end else begin
          res[0]  = '{value_byte: 8'h00, byte_present: 1'b0,
                      lookup_done: 1'b1, field_found: 1'b0};
          res_n   = 2'd1;
          phase_d = PH_FINISHED;
        end
      end
      PH_SKIP, PH_VALUE: begin
        if (phase_q == PH_SKIP && b == CH_SPACE) begin
          phase_d = phase_q;
        end else if (b == CH_CR || b == CH_LF) begin
          res[0]  = '{value_byte: 8'h00, byte_present: 1'b0,
                      lookup_done: 1'b1, field_found: nonempty_q};
          res_n   = 2'd1;
          phase_d = PH_FINISHED;
        end else begin
          res[0]     = '{value_byte: b, byte_present: 1'b1,
                         lookup_done: 1'b0, field_found: 1'b0};
          res_n      = 2'd1;
          nonempty_d = 1'b1;
          phase_d    = PH_VALUE;
        end
      end
      PH_FINISHED: ;
      default: phase_d = PH_FINISHED;
    endcase

    if (in_data_i.end_of_block) begin
      if (phase_d != PH_FINISHED) begin
        // final request after any value byte of this step
        if (res_n == 2'd0) begin
          res[0] = '{value_byte: 8'h00, byte_present: 1'b0,
                     lookup_done: 1'b1, field_found: nonempty_d};
        end else begin
          res[1] = '{value_byte: 8'h00, byte_present: 1'b0,
                     lookup_done: 1'b1, field_found: nonempty_d};
        end
        res_n = res_n + 2'd1;
      end
      phase_d    = PH_SEARCH;
      nonempty_d = 1'b0;
      seen_d     = '0;
      for (int i = 0; i < WIN_D; i++) begin
        win_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEARCH;
      nonempty_q <= 1'b0;
      seen_q     <= '0;
      for (int i = 0; i < WIN_D; i++) begin
        win_q[i] <= '0;
      end
    end else if (in_acc) begin
      phase_q    <= phase_d;
      nonempty_q <= nonempty_d;
      seen_q     <= seen_d;
      for (int i = 0; i < WIN_D; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // ---------------------------------------------------------------- output queue
  hfve_out_t       q_mem [Q_D];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] cnt_q;
  logic            out_acc;
  logic [1:0]      push_n;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_mem[rd_ptr_q];
  assign out_acc     = out_valid_o && !out_stall_i;
  // need room for two results
  assign in_stall_o  = (cnt_q > Q_CW'(Q_D - 2));
  assign push_n      = in_acc ? res_n : 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_q] <= res[0];
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_q + Q_AW'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + Q_AW'(push_n);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      cnt_q <= cnt_q + Q_CW'(push_n) - Q_CW'(out_acc);
    end
  end

  // ---------------------------------------------------------------- checks
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_D))
    else $error("output queue overflow");

  a_block_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_block) |=>
      (phase_q == PH_SEARCH) && (seen_q == '0) && !nonempty_q)
    else $error("scan state not cleared at block end");

  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_n == 2'd2) |-> res[0].byte_present && res[1].lookup_done)
    else $error("two results must be value byte then final");

  a_nonempty_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty_q |-> (phase_q == PH_VALUE || phase_q == PH_FINISHED))
    else $error("value seen outside value phase");

  a_final_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_FINISHED && !in_data_i.end_of_block) |-> res_n == 2'd0)
    else $error("result after lookup finished");

endmodule

`default_nettype wire
